@@ hw/rtl/mvna_pkg.sv @@
// Shared types and codes for the mesh vertex normal accumulator.
// Used by the top, front end, back end and normalizer; depends on nothing.
package mvna_pkg;

    localparam int IDX_W  = 10;
    localparam int POS_W  = 16;
    localparam int NRM_W  = 16;
    localparam int CNT_W  = 11;
    // Wide enough for a cross product of two 17-bit edges and a 24-bit sum.
    localparam int VEC_W  = 36;
    localparam int SUM_W  = 24;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_FACE   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    // The last operation code is not assigned and is answered as out of range.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_DEGEN = 2'd2;

    typedef struct packed {
        logic [1:0]              operation;
        logic [IDX_W-1:0]        index_a;
        logic [IDX_W-1:0]        index_b;
        logic [IDX_W-1:0]        index_c;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } mvna_in_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic [1:0]              status;
    } mvna_out_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        logic                    bad;
        logic [1:0]              operation;
        logic [IDX_W-1:0]        index_a;
        logic [IDX_W-1:0]        index_b;
        logic [IDX_W-1:0]        index_c;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } mvna_cmd_t;

endpackage

@@ hw/rtl/mesh_vertex_normal_accumulator.sv @@
// Items pass through the front-end register and the command queue to the back end, which
// takes one item at a time and holds the next in the queue until it is done. A load or a
// rejected item does not use the normalizer; a read or a face waits on it (a 32-step square
// root and a bit-serial divider run once per component).
// Reset clears the control state and vertex_count; memories hold no value until loaded.
module mesh_vertex_normal_accumulator #(
    parameter int VERTEX_DEPTH         = 1024,
    parameter int NORMAL_FRACTION_BITS = 14
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  mvna_pkg::mvna_in_t               item,
    output logic                             empty,
    input  logic                             pop,
    output mvna_pkg::mvna_out_t              result,
    input  logic                             cfg_we,
    input  logic [mvna_pkg::CNT_W-1:0]       cfg_wdata
);

    localparam int CMD_W = $bits(mvna_pkg::mvna_cmd_t);
    localparam int OUT_W = $bits(mvna_pkg::mvna_out_t);

    logic [mvna_pkg::CNT_W-1:0] vertex_count_reg;
    logic                       cmd_push;
    logic                       cmd_full;
    logic                       cmd_pop;
    logic                       cmd_empty;
    mvna_pkg::mvna_cmd_t        cmd_in;
    logic [CMD_W-1:0]           cmd_out;
    logic                       out_push;
    logic                       out_full;
    mvna_pkg::mvna_out_t        res;
    logic [OUT_W-1:0]           out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vertex_count_reg <= '0;
        else if (cfg_we)
            vertex_count_reg <= cfg_wdata;
    end

    mvna_front #(
        .VERTEX_DEPTH(VERTEX_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .vertex_count(vertex_count_reg),
        .cmd_push    (cmd_push),
        .cmd_full    (cmd_full),
        .cmd         (cmd_in)
    );

    mvna_fifo #(
        .WIDTH(CMD_W)
    ) u_cmd_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (cmd_push),
        .full (cmd_full),
        .din  (cmd_in),
        .pop  (cmd_pop),
        .empty(cmd_empty),
        .dout (cmd_out)
    );

    mvna_back #(
        .VERTEX_DEPTH        (VERTEX_DEPTH),
        .NORMAL_FRACTION_BITS(NORMAL_FRACTION_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_empty(cmd_empty),
        .cmd_pop  (cmd_pop),
        .cmd      (mvna_pkg::mvna_cmd_t'(cmd_out)),
        .out_full (out_full),
        .out_push (out_push),
        .res      (res)
    );

    mvna_fifo #(
        .WIDTH(OUT_W)
    ) u_out_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (out_push),
        .full (out_full),
        .din  (res),
        .pop  (pop),
        .empty(empty),
        .dout (out_data)
    );

    assign result = mvna_pkg::mvna_out_t'(out_data);

endmodule

@@ hw/rtl/mvna_fifo.sv @@
// Two-entry queue used between the front end, the back end and the result port.
// Depends on nothing.
module mvna_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] data_reg [2];
    logic             wp_reg;
    logic             rp_reg;
    logic [1:0]       cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign dout    = data_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wp_reg <= !wp_reg;
            if (do_pop)
                rp_reg <= !rp_reg;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            data_reg[wp_reg] <= din;
    end

endmodule

@@ hw/rtl/mvna_front.sv @@
// Front end: takes input items, checks indices and the operation code.
// Depends on mvna_pkg; feeds the command queue.
module mvna_front #(
    parameter int VERTEX_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  mvna_pkg::mvna_in_t                item,
    input  logic [mvna_pkg::CNT_W-1:0]        vertex_count,
    output logic                              cmd_push,
    input  logic                              cmd_full,
    output mvna_pkg::mvna_cmd_t               cmd
);

    localparam int LIM_W = 17;

    logic                valid_reg;
    mvna_pkg::mvna_cmd_t cmd_reg;
    logic [LIM_W-1:0]    lim;
    logic                ok_a;
    logic                ok_b;
    logic                ok_c;
    logic                bad;
    logic                accept;

    assign full     = valid_reg && cmd_full;
    assign accept   = push && !full;
    assign cmd_push = valid_reg && !cmd_full;
    assign cmd      = cmd_reg;

    always_comb
    begin
        if (LIM_W'(vertex_count) < LIM_W'(VERTEX_DEPTH))
            lim = LIM_W'(vertex_count);
        else
            lim = LIM_W'(VERTEX_DEPTH);
        ok_a = LIM_W'(item.index_a) < lim;
        ok_b = LIM_W'(item.index_b) < lim;
        ok_c = LIM_W'(item.index_c) < lim;
        case (item.operation)
            mvna_pkg::OP_LOAD: bad = !ok_a;
            mvna_pkg::OP_READ: bad = !ok_a;
            mvna_pkg::OP_FACE: bad = !(ok_a && ok_b && ok_c);
            default:           bad = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (cmd_push)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.bad       <= bad;
            cmd_reg.operation <= item.operation;
            cmd_reg.index_a   <= item.index_a;
            cmd_reg.index_b   <= item.index_b;
            cmd_reg.index_c   <= item.index_c;
            cmd_reg.pos_x     <= item.pos_x;
            cmd_reg.pos_y     <= item.pos_y;
            cmd_reg.pos_z     <= item.pos_z;
        end
    end

endmodule

@@ hw/rtl/mvna_norm.sv @@
// Normalizer: scales a vector to unit length with a bit-serial square root
// and a restoring divider shared by the three components. Depends on mvna_pkg.
module mvna_norm #(
    parameter int NORMAL_FRACTION_BITS = 14
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [mvna_pkg::VEC_W-1:0]       vec [3],
    output logic                                    done,
    output logic                                    zero,
    output logic signed [NORMAL_FRACTION_BITS+1:0]  n [3]
);

    localparam int F    = NORMAL_FRACTION_BITS;
    localparam int VW   = mvna_pkg::VEC_W;
    localparam int MW   = 30;
    localparam int SW   = 63;
    localparam int LW   = 31;
    localparam int QW   = F + 2;
    localparam int NUMW = MW + F + 1;
    localparam int RW   = 33;
    localparam int CW   = $clog2(QW + 1);

    typedef enum logic [2:0] {
        N_IDLE, N_SHIFT, N_SQ, N_SUM, N_SQRT, N_DIVSET, N_DIV, N_DONE
    } state_t;

    state_t            state_reg;
    logic [VW-1:0]     mag_reg [3];
    logic              neg_reg [3];
    logic [MW-1:0]     mp_reg [3];
    logic [2*MW-1:0]   sq_reg [3];
    logic [SW-1:0]     rem_s_reg;
    logic [SW-1:0]     root_reg;
    logic [SW-1:0]     bit_reg;
    logic [LW-1:0]     len_reg;
    logic [1:0]        k_reg;
    logic [RW-1:0]     rem_reg;
    logic [QW-1:0]     shin_reg;
    logic [QW-1:0]     q_reg;
    logic [CW-1:0]     cnt_reg;
    logic              zero_reg;
    logic signed [QW-1:0] n_reg [3];

    logic [VW-1:0]     mx;
    logic [2:0]        sh;
    logic [SW-1:0]     s2;
    logic [SW-1:0]     trial_s;
    logic [SW-1:0]     root_next;
    logic [NUMW-1:0]   num;
    logic [RW-1:0]     trial;
    logic [RW-1:0]     rem_next;
    logic [QW-1:0]     q_next;
    logic [QW-1:0]     q_cap;
    logic [MW-1:0]     mp_k;

    assign done = (state_reg == N_DONE);
    assign zero = zero_reg;
    assign n    = n_reg;

    always_comb
    begin
        mx = mag_reg[0];
        if (mag_reg[1] > mx)
            mx = mag_reg[1];
        if (mag_reg[2] > mx)
            mx = mag_reg[2];
        // Smallest shift that brings the largest magnitude below 2^30.
        sh = 3'd0;
        for (int i = 0; i < VW - MW; i++)
        begin
            if (mx[MW+i])
                sh = 3'(i + 1);
        end

        s2 = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);

        trial_s = root_reg + bit_reg;
        if (rem_s_reg >= trial_s)
            root_next = (root_reg >> 1) + bit_reg;
        else
            root_next = root_reg >> 1;

        case (k_reg)
            2'd0:    mp_k = mp_reg[0];
            2'd1:    mp_k = mp_reg[1];
            default: mp_k = mp_reg[2];
        endcase
        num = {1'b0, mp_k, F'(0)} + NUMW'(len_reg >> 1);

        trial = {rem_reg[RW-2:0], shin_reg[QW-1]};
        if (trial >= RW'(len_reg))
        begin
            rem_next = trial - RW'(len_reg);
            q_next   = {q_reg[QW-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial;
            q_next   = {q_reg[QW-2:0], 1'b0};
        end
        if (q_next > QW'(1) << F)
            q_cap = QW'(1) << F;
        else
            q_cap = q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            zero_reg  <= 1'b0;
            k_reg     <= 2'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            neg_reg[i] <= vec[i][VW-1];
                            mag_reg[i] <= vec[i][VW-1] ? VW'(-vec[i]) : VW'(vec[i]);
                        end
                        state_reg <= N_SHIFT;
                    end
                end
                N_SHIFT:
                begin
                    for (int i = 0; i < 3; i++)
                        mp_reg[i] <= MW'(mag_reg[i] >> sh);
                    state_reg <= N_SQ;
                end
                N_SQ:
                begin
                    for (int i = 0; i < 3; i++)
                        sq_reg[i] <= mp_reg[i] * mp_reg[i];
                    state_reg <= N_SUM;
                end
                N_SUM:
                begin
                    rem_s_reg <= s2;
                    root_reg  <= '0;
                    bit_reg   <= SW'(1) << (SW - 1);
                    k_reg     <= 2'd0;
                    if (s2 == '0)
                    begin
                        zero_reg <= 1'b1;
                        for (int i = 0; i < 3; i++)
                            n_reg[i] <= '0;
                        state_reg <= N_DONE;
                    end
                    else
                    begin
                        zero_reg  <= 1'b0;
                        state_reg <= N_SQRT;
                    end
                end
                N_SQRT:
                begin
                    if (rem_s_reg >= trial_s)
                        rem_s_reg <= rem_s_reg - trial_s;
                    root_reg <= root_next;
                    bit_reg  <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        len_reg   <= LW'(root_next);
                        state_reg <= N_DIVSET;
                    end
                end
                N_DIVSET:
                begin
                    rem_reg   <= RW'(num[NUMW-1:QW]);
                    shin_reg  <= num[QW-1:0];
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= N_DIV;
                end
                N_DIV:
                begin
                    rem_reg  <= rem_next;
                    q_reg    <= q_next;
                    shin_reg <= shin_reg << 1;
                    cnt_reg  <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(QW - 1))
                    begin
                        n_reg[k_reg] <= neg_reg[k_reg] ? -$signed(q_cap) : $signed(q_cap);
                        if (k_reg == 2'd2)
                            state_reg <= N_DONE;
                        else
                        begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= N_DIVSET;
                        end
                    end
                end
                N_DONE:
                    state_reg <= N_IDLE;
                default:
                    state_reg <= N_IDLE;
            endcase
        end
    end

endmodule

@@ hw/rtl/mvna_back.sv @@
// Back end: position and normal-sum memories, edge and cross product,
// sum updates and result formation. Depends on mvna_pkg and mvna_norm.
module mvna_back #(
    parameter int VERTEX_DEPTH         = 1024,
    parameter int NORMAL_FRACTION_BITS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    input  mvna_pkg::mvna_cmd_t cmd,
    input  logic                out_full,
    output logic                out_push,
    output mvna_pkg::mvna_out_t res
);

    localparam int AW  = $clog2(VERTEX_DEPTH);
    localparam int NW  = NORMAL_FRACTION_BITS + 2;
    localparam int VW  = mvna_pkg::VEC_W;
    localparam int SMW = mvna_pkg::SUM_W;
    localparam int PW  = mvna_pkg::POS_W;

    typedef enum logic [3:0] {
        B_IDLE, B_LOAD, B_RD_A, B_RD_B, B_RD_C, B_LAT_C, B_EDGE, B_MUL,
        B_CROSS, B_SUM_RD, B_SUM_LAT, B_NORM, B_UPD_RD, B_UPD_WR, B_EMIT
    } state_t;

    state_t              state_reg;
    mvna_pkg::mvna_cmd_t cmd_reg;
    mvna_pkg::mvna_out_t res_reg;
    logic [1:0]          corner_reg;
    logic                start_reg;

    logic [3*PW-1:0]     pos_mem [VERTEX_DEPTH];
    logic [3*SMW-1:0]    sum_mem [VERTEX_DEPTH];
    logic [3*PW-1:0]     pos_rdata_reg;
    logic [3*SMW-1:0]    sum_rdata_reg;

    logic signed [PW-1:0]   pa_reg [3];
    logic signed [PW-1:0]   pb_reg [3];
    logic signed [PW-1:0]   pc_reg [3];
    logic signed [PW:0]     e1_reg [3];
    logic signed [PW:0]     e2_reg [3];
    logic signed [2*PW+1:0] p_reg [6];
    logic signed [VW-1:0]   vec_reg [3];
    logic signed [NW-1:0]   n_reg [3];

    logic                 norm_done;
    logic                 norm_zero;
    logic signed [NW-1:0] norm_n [3];

    logic [AW-1:0]        addr_a;
    logic [AW-1:0]        corner_addr;
    logic [AW-1:0]        pos_raddr;
    logic [AW-1:0]        sum_addr;
    logic                 pos_we;
    logic                 sum_we;
    logic [3*SMW-1:0]     sum_wdata;
    logic signed [SMW-1:0] sum_old [3];
    logic signed [SMW:0]   sum_wide [3];
    logic signed [SMW-1:0] sum_new [3];

    function automatic logic signed [15:0] to_port(input logic signed [NW-1:0] v);
        logic signed [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    mvna_norm #(
        .NORMAL_FRACTION_BITS(NORMAL_FRACTION_BITS)
    ) u_norm (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start_reg),
        .vec  (vec_reg),
        .done (norm_done),
        .zero (norm_zero),
        .n    (norm_n)
    );

    assign cmd_pop  = (state_reg == B_IDLE) && !cmd_empty;
    assign out_push = (state_reg == B_EMIT) && !out_full;
    assign res      = res_reg;
    assign pos_we   = (state_reg == B_LOAD);
    assign sum_we   = (state_reg == B_LOAD) || (state_reg == B_UPD_WR);

    always_comb
    begin
        addr_a = AW'(cmd_reg.index_a);
        case (corner_reg)
            2'd0:    corner_addr = AW'(cmd_reg.index_a);
            2'd1:    corner_addr = AW'(cmd_reg.index_b);
            default: corner_addr = AW'(cmd_reg.index_c);
        endcase
        case (state_reg)
            B_RD_B:  pos_raddr = AW'(cmd_reg.index_b);
            B_RD_C:  pos_raddr = AW'(cmd_reg.index_c);
            default: pos_raddr = addr_a;
        endcase
        if (state_reg == B_UPD_RD || state_reg == B_UPD_WR)
            sum_addr = corner_addr;
        else
            sum_addr = addr_a;

        sum_old[0] = $signed(sum_rdata_reg[3*SMW-1:2*SMW]);
        sum_old[1] = $signed(sum_rdata_reg[2*SMW-1:SMW]);
        sum_old[2] = $signed(sum_rdata_reg[SMW-1:0]);
        for (int i = 0; i < 3; i++)
        begin
            sum_wide[i] = (SMW+1)'(sum_old[i]) + (SMW+1)'(n_reg[i]);
            if (sum_wide[i][SMW] != sum_wide[i][SMW-1])
                sum_new[i] = sum_wide[i][SMW] ? {1'b1, {(SMW-1){1'b0}}}
                                              : {1'b0, {(SMW-1){1'b1}}};
            else
                sum_new[i] = sum_wide[i][SMW-1:0];
        end
        if (state_reg == B_LOAD)
            sum_wdata = '0;
        else
            sum_wdata = {sum_new[0], sum_new[1], sum_new[2]};
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[addr_a] <= {cmd_reg.pos_x, cmd_reg.pos_y, cmd_reg.pos_z};
        if (sum_we)
            sum_mem[sum_addr] <= sum_wdata;
        pos_rdata_reg <= pos_mem[pos_raddr];
        sum_rdata_reg <= sum_mem[sum_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            start_reg  <= 1'b0;
            corner_reg <= 2'd0;
        end
        else
        begin
            // The normalizer is started once, right after its input vector is loaded.
            start_reg <= (state_reg == B_CROSS) || (state_reg == B_SUM_LAT);
            case (state_reg)
                B_IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        cmd_reg    <= cmd;
                        corner_reg <= 2'd0;
                        res_reg    <= '{normal_x: '0, normal_y: '0, normal_z: '0,
                                        status: cmd.bad ? mvna_pkg::ST_RANGE
                                                        : mvna_pkg::ST_OK};
                        if (cmd.bad)
                            state_reg <= B_EMIT;
                        else
                        begin
                            case (cmd.operation)
                                mvna_pkg::OP_LOAD: state_reg <= B_LOAD;
                                mvna_pkg::OP_FACE: state_reg <= B_RD_A;
                                mvna_pkg::OP_READ: state_reg <= B_SUM_RD;
                                default:           state_reg <= B_EMIT;
                            endcase
                        end
                    end
                end
                B_LOAD:
                    state_reg <= B_EMIT;
                B_RD_A:
                    state_reg <= B_RD_B;
                B_RD_B:
                begin
                    pa_reg[0] <= $signed(pos_rdata_reg[3*PW-1:2*PW]);
                    pa_reg[1] <= $signed(pos_rdata_reg[2*PW-1:PW]);
                    pa_reg[2] <= $signed(pos_rdata_reg[PW-1:0]);
                    state_reg <= B_RD_C;
                end
                B_RD_C:
                begin
                    pb_reg[0] <= $signed(pos_rdata_reg[3*PW-1:2*PW]);
                    pb_reg[1] <= $signed(pos_rdata_reg[2*PW-1:PW]);
                    pb_reg[2] <= $signed(pos_rdata_reg[PW-1:0]);
                    state_reg <= B_LAT_C;
                end
                B_LAT_C:
                begin
                    pc_reg[0] <= $signed(pos_rdata_reg[3*PW-1:2*PW]);
                    pc_reg[1] <= $signed(pos_rdata_reg[2*PW-1:PW]);
                    pc_reg[2] <= $signed(pos_rdata_reg[PW-1:0]);
                    state_reg <= B_EDGE;
                end
                B_EDGE:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        e1_reg[i] <= (PW+1)'(pb_reg[i]) - (PW+1)'(pa_reg[i]);
                        e2_reg[i] <= (PW+1)'(pc_reg[i]) - (PW+1)'(pa_reg[i]);
                    end
                    state_reg <= B_MUL;
                end
                B_MUL:
                begin
                    p_reg[0]  <= e1_reg[1] * e2_reg[2];
                    p_reg[1]  <= e1_reg[2] * e2_reg[1];
                    p_reg[2]  <= e1_reg[2] * e2_reg[0];
                    p_reg[3]  <= e1_reg[0] * e2_reg[2];
                    p_reg[4]  <= e1_reg[0] * e2_reg[1];
                    p_reg[5]  <= e1_reg[1] * e2_reg[0];
                    state_reg <= B_CROSS;
                end
                B_CROSS:
                begin
                    vec_reg[0] <= VW'(p_reg[0]) - VW'(p_reg[1]);
                    vec_reg[1] <= VW'(p_reg[2]) - VW'(p_reg[3]);
                    vec_reg[2] <= VW'(p_reg[4]) - VW'(p_reg[5]);
                    state_reg  <= B_NORM;
                end
                B_SUM_RD:
                    state_reg <= B_SUM_LAT;
                B_SUM_LAT:
                begin
                    for (int i = 0; i < 3; i++)
                        vec_reg[i] <= VW'(sum_old[i]);
                    state_reg <= B_NORM;
                end
                B_NORM:
                begin
                    if (norm_done)
                    begin
                        if (norm_zero)
                        begin
                            res_reg.status <= mvna_pkg::ST_DEGEN;
                            state_reg      <= B_EMIT;
                        end
                        else
                        begin
                            n_reg            <= norm_n;
                            res_reg.normal_x <= to_port(norm_n[0]);
                            res_reg.normal_y <= to_port(norm_n[1]);
                            res_reg.normal_z <= to_port(norm_n[2]);
                            if (cmd_reg.operation == mvna_pkg::OP_FACE)
                                state_reg <= B_UPD_RD;
                            else
                                state_reg <= B_EMIT;
                        end
                    end
                end
                B_UPD_RD:
                    state_reg <= B_UPD_WR;
                B_UPD_WR:
                begin
                    // Each corner is written back before the next is read, so
                    // repeated corners accumulate correctly.
                    if (corner_reg == 2'd2)
                        state_reg <= B_EMIT;
                    else
                    begin
                        corner_reg <= corner_reg + 2'd1;
                        state_reg  <= B_UPD_RD;
                    end
                end
                B_EMIT:
                begin
                    if (!out_full)
                        state_reg <= B_IDLE;
                end
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

@@ tb/mesh_vertex_normal_accumulator_test.sv @@
// Self-checking testbench for the mesh vertex normal accumulator.
// Depends on mvna_pkg and mesh_vertex_normal_accumulator; predicts each result in-line.
module mesh_vertex_normal_accumulator_test;

    localparam int DEPTH = 1024;
    localparam int FRAC = 14;
    localparam int SUM_MAX = 8388607;
    localparam int SUM_MIN = -8388608;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam longint STALL_AT = 3000;
    localparam int STALL_LEN = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    mvna_pkg::mvna_in_t item = '0;
    logic empty;
    logic pop = 1'b0;
    mvna_pkg::mvna_out_t result;
    logic cfg_we = 1'b0;
    logic [mvna_pkg::CNT_W-1:0] cfg_wdata = '0;

    mesh_vertex_normal_accumulator dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // Predictor state.
    int unsigned model_count;
    int model_pos [DEPTH][3];
    int model_sum [DEPTH][3];

    mvna_pkg::mvna_in_t pending_items[$];
    mvna_pkg::mvna_out_t expected_normals[$];
    int errors = 0;
    longint cycle_count = 0;
    bit accepted = 1'b0;
    int hold_off = 0;
    int burst_left = 0;
    int gap_left = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void queue_item(mvna_pkg::mvna_in_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Returns 0 for a zero-length vector.
    function automatic bit unit_vector(input longint v[3], output longint n[3]);
        longint unsigned m[3], mx, s2, len, q;
        int sh;
        mx = 0;
        s2 = 0;
        sh = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        while ((mx >> sh) >= (64'd1 << 30)) sh++;
        for (int i = 0; i < 3; i++)
        begin
            m[i] >>= sh;
            s2 += m[i] * m[i];
        end
        for (int i = 0; i < 3; i++) n[i] = 0;
        if (s2 == 0) return 1'b0;
        len = isqrt(s2);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << FRAC) + (len >> 1)) / len;
            if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
            n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic bit index_ok(int unsigned idx);
        int unsigned lim;
        lim = model_count < DEPTH ? model_count : DEPTH;
        return idx < lim;
    endfunction

    function automatic mvna_pkg::mvna_out_t predict_normal(mvna_pkg::mvna_in_t it);
        mvna_pkg::mvna_out_t r;
        longint n[3], e1[3], e2[3], c[3], s[3], t;
        int idx[3];
        r = '0;
        for (int i = 0; i < 3; i++) n[i] = 0;
        r.status = mvna_pkg::ST_OK;
        idx[0] = int'(it.index_a);
        idx[1] = int'(it.index_b);
        idx[2] = int'(it.index_c);
        if (it.operation == mvna_pkg::OP_LOAD)
        begin
            if (index_ok(idx[0]))
            begin
                model_pos[idx[0]][0] = int'(it.pos_x);
                model_pos[idx[0]][1] = int'(it.pos_y);
                model_pos[idx[0]][2] = int'(it.pos_z);
                for (int i = 0; i < 3; i++) model_sum[idx[0]][i] = 0;
            end
            else
                r.status = mvna_pkg::ST_RANGE;
        end
        else if (it.operation == mvna_pkg::OP_FACE)
        begin
            if (index_ok(idx[0]) && index_ok(idx[1]) && index_ok(idx[2]))
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e1[i] = longint'(model_pos[idx[1]][i]) - model_pos[idx[0]][i];
                    e2[i] = longint'(model_pos[idx[2]][i]) - model_pos[idx[0]][i];
                end
                c[0] = e1[1] * e2[2] - e1[2] * e2[1];
                c[1] = e1[2] * e2[0] - e1[0] * e2[2];
                c[2] = e1[0] * e2[1] - e1[1] * e2[0];
                if (unit_vector(c, n))
                begin
                    for (int k = 0; k < 3; k++)
                        for (int i = 0; i < 3; i++)
                        begin
                            t = longint'(model_sum[idx[k]][i]) + n[i];
                            if (t > SUM_MAX) t = SUM_MAX;
                            if (t < SUM_MIN) t = SUM_MIN;
                            model_sum[idx[k]][i] = int'(t);
                        end
                end
                else
                    r.status = mvna_pkg::ST_DEGEN;
            end
            else
                r.status = mvna_pkg::ST_RANGE;
        end
        else if (it.operation == mvna_pkg::OP_READ)
        begin
            if (index_ok(idx[0]))
            begin
                for (int i = 0; i < 3; i++) s[i] = model_sum[idx[0]][i];
                if (!unit_vector(s, n)) r.status = mvna_pkg::ST_DEGEN;
            end
            else
                r.status = mvna_pkg::ST_RANGE;
        end
        else
            r.status = mvna_pkg::ST_RANGE;
        r.normal_x = n[0][15:0];
        r.normal_y = n[1][15:0];
        r.normal_z = n[2][15:0];
        return r;
    endfunction

    // Each accepted transfer is predicted and leaves the pending queue here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        accepted = push && !full;
        if (accepted)
        begin
            expected_normals.insert(expected_normals.size(), predict_normal(item));
            void'(pending_items.pop_front());
        end
    end

    // Sender: bursts with random gaps; an offered item stays until it is taken.
    always @(negedge clk)
    begin
        if (!rst_n || pending_items.size() == 0)
            push <= 1'b0;
        else if (push && !accepted)
            push <= 1'b1;
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            push <= 1'b0;
        end
        else
        begin
            item <= pending_items[0];
            push <= 1'b1;
            if (burst_left <= 1)
            begin
                burst_left <= int'($urandom_range(1, 30));
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 12));
            end
            else
                burst_left <= burst_left - 1;
        end
    end

    // Receiver: own stall pattern, one long hold-off that fills the block, and
    // occasional shorter ones.
    always @(negedge clk)
    begin
        if (cycle_count == STALL_AT)
        begin
            hold_off <= STALL_LEN;
            pop <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            pop <= 1'b0;
        end
        else if ($urandom_range(0, 999) == 0)
        begin
            hold_off <= int'($urandom_range(200, 600));
            pop <= 1'b0;
        end
        else
            pop <= (cycle_count % 256 < 128) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    always @(posedge clk)
    begin
        mvna_pkg::mvna_out_t want;
        if (pop && !empty)
        begin
            if (expected_normals.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                errors++;
            end
            else
            begin
                want = expected_normals.pop_front();
                if (result.normal_x !== want.normal_x || result.normal_y !== want.normal_y
                    || result.normal_z !== want.normal_z || result.status !== want.status)
                begin
                    $display("%0t: expected x=%0d y=%0d z=%0d st=%0d, got x=%0d y=%0d z=%0d st=%0d",
                        $time, want.normal_x, want.normal_y, want.normal_z, want.status,
                        result.normal_x, result.normal_y, result.normal_z, result.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic mvna_pkg::mvna_in_t make_item(logic [1:0] op, int a, int b, int c,
                                                     int x, int y, int z);
        mvna_pkg::mvna_in_t it;
        it.operation = op;
        it.index_a = a[mvna_pkg::IDX_W-1:0];
        it.index_b = b[mvna_pkg::IDX_W-1:0];
        it.index_c = c[mvna_pkg::IDX_W-1:0];
        it.pos_x = x[mvna_pkg::POS_W-1:0];
        it.pos_y = y[mvna_pkg::POS_W-1:0];
        it.pos_z = z[mvna_pkg::POS_W-1:0];
        return it;
    endfunction

    function automatic int rand_index();
        return int'($urandom_range(0, 1023));
    endfunction

    // An index outside the valid range where one exists, else a loaded vertex.
    function automatic int far_index(int valid_lim, int lim);
        if (valid_lim < DEPTH) return int'($urandom_range(valid_lim, 1023));
        return int'($urandom_range(0, lim - 1));
    endfunction

    function automatic int rand_coord(bit wide);
        if (wide || $urandom_range(0, 5) == 0) return int'($urandom_range(0, 65535)) - 32768;
        return int'($urandom_range(0, 2000)) - 1000;
    endfunction

    task automatic drain_and_write(int unsigned count);
        while (pending_items.size() != 0 || push || expected_normals.size() != 0)
            @(posedge clk);
        repeat (120) @(negedge clk);
        cfg_wdata <= count[mvna_pkg::CNT_W-1:0];
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        model_count = count;
    endtask

    // Random phase: load the vertices in use, then mostly faces and reads.
    task automatic random_phase(int n_items, int unsigned count, int span);
        int lim, valid_lim, a, b, c;
        bit wide;
        valid_lim = count < DEPTH ? int'(count) : DEPTH;
        lim = valid_lim;
        if (lim > span) lim = span;
        wide = ($urandom_range(0, 1) == 1);
        for (int v = 0; v < lim; v++)
            queue_item(make_item(mvna_pkg::OP_LOAD, v, rand_index(), rand_index(),
                rand_coord(wide), rand_coord(wide), rand_coord(wide)));
        for (int k = 0; k < n_items; k++)
        begin
            a = int'($urandom_range(0, lim - 1));
            b = int'($urandom_range(0, lim - 1));
            c = int'($urandom_range(0, lim - 1));
            case ($urandom_range(0, 19))
                0: queue_item(make_item(mvna_pkg::OP_UNUSED, rand_index(), rand_index(),
                    rand_index(), 0, 0, 0));
                1: queue_item(make_item(mvna_pkg::OP_FACE, a, far_index(valid_lim, lim), c,
                    0, 0, 0));
                2, 3: queue_item(make_item(mvna_pkg::OP_LOAD, a, rand_index(), rand_index(),
                    rand_coord(wide), rand_coord(wide), rand_coord(wide)));
                4, 5, 6, 7, 8: queue_item(make_item(mvna_pkg::OP_READ, a, rand_index(),
                    rand_index(), rand_coord(1), rand_coord(1), rand_coord(1)));
                default: queue_item(make_item(mvna_pkg::OP_FACE, a, b, c,
                    rand_coord(1), rand_coord(1), rand_coord(1)));
            endcase
        end
    endtask

    initial
    begin
        model_count = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // With no vertices configured every index is out of range.
        queue_item(make_item(mvna_pkg::OP_LOAD, 0, 0, 0, 1, 2, 3));
        queue_item(make_item(mvna_pkg::OP_READ, 1023, 0, 0, 0, 0, 0));
        drain_and_write(4);
        queue_item(make_item(mvna_pkg::OP_LOAD, 0, 1023, 1023, -32768, -32768, -32768));
        queue_item(make_item(mvna_pkg::OP_LOAD, 1, 0, 0, 32767, -32768, -32768));
        queue_item(make_item(mvna_pkg::OP_LOAD, 2, 0, 0, -32768, 32767, -32768));
        queue_item(make_item(mvna_pkg::OP_LOAD, 3, 0, 0, -32768, -32768, -32768));
        queue_item(make_item(mvna_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
        queue_item(make_item(mvna_pkg::OP_FACE, 0, 1, 2, 0, 0, 0));
        queue_item(make_item(mvna_pkg::OP_FACE, 0, 0, 1, 0, 0, 0));
        queue_item(make_item(mvna_pkg::OP_FACE, 0, 1, 3, 0, 0, 0));
        queue_item(make_item(mvna_pkg::OP_FACE, 0, 1, 4, 0, 0, 0));
        queue_item(make_item(mvna_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
        queue_item(make_item(mvna_pkg::OP_READ, 3, 0, 0, 0, 0, 0));
        queue_item(make_item(mvna_pkg::OP_READ, 4, 0, 0, 0, 0, 0));
        queue_item(make_item(mvna_pkg::OP_UNUSED, 1023, 1023, 1023, -1, -1, -1));
        // Many repeats of one face drive the sums into saturation.
        for (int k = 0; k < 700; k++)
            queue_item(make_item(mvna_pkg::OP_FACE, 0, 1, 2, 0, 0, 0));
        queue_item(make_item(mvna_pkg::OP_READ, 1, 0, 0, 0, 0, 0));

        drain_and_write(1024);
        random_phase(250, 1024, 128);
        drain_and_write(2047);
        random_phase(200, 2047, 64);
        drain_and_write(7);
        random_phase(150, 7, 7);
        drain_and_write(3);
        random_phase(150, 3, 3);

        while (pending_items.size() != 0 || push || expected_normals.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
